### sv/cfss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfss_pkg - shared types and constants of the frame size search
// payload structs, result kinds, controller command and status bundles
// ----------------------------------------------------------------------------
package cfss_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned TIME_W   = 24;
  localparam int unsigned HP_W     = 32;
  localparam int unsigned MINF_W   = 16;
  localparam int unsigned FRAME_W  = 17;
  localparam int unsigned CAND_W   = FRAME_W + 1;
  localparam int unsigned PROD_W   = HP_W + PERIOD_W;
  localparam int unsigned STEP_W   = $clog2(HP_W);

  // result kinds
  localparam logic [1:0] KIND_SUMMARY = 2'd0;
  localparam logic [1:0] KIND_FOUND   = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;
  localparam logic [1:0] KIND_CUT     = 2'd3;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   phase;
    logic [TIME_W-1:0]   exec_time;
    logic [TIME_W-1:0]   deadline;
    logic                last_task;
  } task_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [HP_W-1:0]    hyperperiod;
    logic [MINF_W-1:0]  min_frame;
    logic [FRAME_W-1:0] max_frame;
    logic [FRAME_W-1:0] frame_size;
    logic               overflow;
    logic               last_result;
  } result_t;

  // operand selection of the shared divider
  typedef enum logic [1:0] {
    DIV_GCD,
    DIV_LCM,
    DIV_SEARCH
  } div_sel_e;

  typedef struct packed {
    logic       load_task;
    logic       div_start;
    div_sel_e   div_sel;
    logic       gcd_step;
    logic       lcm_mul;
    logic       lcm_store;
    logic       prep;
    logic       emit;
    logic [1:0] emit_kind;
    logic       emit_last;
    logic       take;
    logic       cand_inc;
    logic       clear_run;
  } cmd_t;

  typedef struct packed {
    logic need_gcd;
    logic b_zero;
    logic div_done;
    logic rem_zero;
    logic cand_above;
    logic last_task;
    logic out_free;
    logic count_zero;
    logic count_full;
  } status_t;

endpackage
`default_nettype wire

### sv/cfss_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfss_stream_if - valid/ready channel
// one transfer per clock edge with valid and ready both high
// ----------------------------------------------------------------------------
interface cfss_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/cyclic_frame_size_search_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cyclic_frame_size_search_core - cyclic executive frame size search
// accumulates hyperperiod, largest execution time and largest window over a
// task set, then lists up to MAX_FOUND frame sizes in range that divide the hyperperiod
// ----------------------------------------------------------------------------
//
//  channel    dir   payload              transfer when
//  ---------  ----  -------------------  ---------------------------
//  task_i     in    cfss_pkg::task_t     task_i.valid & task_i.ready
//  result_o   out   cfss_pkg::result_t   result_o.valid & result_o.ready
//
//  one task at a time; ready is high only while the sequencer is idle
//  a task that starts or follows a saturated set skips the divider; any other
//  runs euclid on the shared divider, one divider pass per remainder step
//  (at most ~24 steps), then one divide and a multiply for the lcm
//  the last task then walks the candidates, and each candidate frame size
//  checked needs one pass of the 32-step divider
//  results leave through a one-deep output register; a stalled result
//  holds the search, task transfers resume once the run is closed
//  reset needs no clearing pass
//
module cyclic_frame_size_search_core #(
  parameter int unsigned MAX_FOUND = 62,
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  cfss_stream_if.sink   task_i,
  cfss_stream_if.source result_o
);
  import cfss_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    ready_w;
  logic    task_ready;
  logic    task_accept;
  logic    out_valid;
  result_t out_data;

  // a task transfer completes only while the sequencer is idle
  assign task_ready   = ready_w;
  assign task_accept  = task_i.valid && task_i.ready;
  assign task_i.ready = task_ready;

  // sequencer: owns the state machine, drives the datapath by command
  cfss_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (task_accept),
    .st_i     (st),
    .cmd_o    (cmd),
    .ready_o  (ready_w)
  );

  // datapath: running values, shared divider, multiplier, output register
  cfss_datapath #(
    .MAX_FOUND (MAX_FOUND),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .task_i      (task_i.data),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_ready_i (result_o.ready)
  );

  assign result_o.valid = out_valid;
  assign result_o.data  = out_data;

endmodule
`default_nettype wire

### sv/cfss_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfss_div - iterative restoring divider
// one quotient bit per cycle, quotient and remainder held after done
// ----------------------------------------------------------------------------
module cfss_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [cfss_pkg::HP_W-1:0]    dividend_i,
  input  wire logic [cfss_pkg::FRAME_W-1:0] divisor_i,
  output logic                             done_o,
  output logic [cfss_pkg::HP_W-1:0]         quo_o,
  output logic [cfss_pkg::FRAME_W-1:0]      rem_o
);
  import cfss_pkg::*;

  logic               busy_q;
  logic [STEP_W-1:0]  cnt_q;
  logic               done_q;
  logic [HP_W-1:0]    quo_q;
  logic [FRAME_W-1:0] rem_q;
  logic [FRAME_W-1:0] dvs_q;

  logic [FRAME_W:0]   rem_sh;
  logic [FRAME_W:0]   rem_sub;
  logic               ge;
  logic [FRAME_W-1:0] rem_d;

  assign rem_sh  = {rem_q, quo_q[HP_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign rem_d   = ge ? rem_sub[FRAME_W-1:0] : rem_sh[FRAME_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_W'(HP_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[HP_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_done_ends_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held for more than one cycle");

endmodule
`default_nettype wire

### sv/cfss_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfss_datapath - running values, gcd/lcm datapath and frame size search
// holds the task registers, shared divider, multiplier and output register
// ----------------------------------------------------------------------------
module cfss_datapath #(
  parameter int unsigned MAX_FOUND = 62,
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfss_pkg::task_t   task_i,
  input  wire cfss_pkg::cmd_t    cmd_i,
  output cfss_pkg::status_t      st_o,
  output logic                   out_valid_o,
  output cfss_pkg::result_t      out_data_o,
  input  wire logic              out_ready_i
);
  import cfss_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FOUND + 1);
  localparam logic [TIME_W:0] RND = (TIME_W + 1)'((1 << FRAC_BITS) - 1);
  localparam logic [TIME_W:0] MX_SAT = (TIME_W + 1)'(1 << MINF_W);

  // running values
  logic [HP_W-1:0]     hyper_q;
  logic                ovf_q;
  logic                first_q;
  logic [TIME_W-1:0]   max_exec_q;
  logic [TIME_W-1:0]   max_win_q;
  logic [CNT_W-1:0]    count_q;
  logic                out_valid_q;

  // per task and search payload
  logic [PERIOD_W-1:0] period_q;
  logic                last_q;
  logic                need_gcd_q;
  logic [HP_W-1:0]     gcd_a_q;
  logic [FRAME_W-1:0]  gcd_b_q;
  logic [PROD_W-1:0]   prod_q;
  logic [MINF_W-1:0]   mn_q;
  logic [FRAME_W-1:0]  mx_q;
  logic [CAND_W-1:0]   cand_q;
  logic [FRAME_W-1:0]  pend_q;
  result_t             out_q;

  logic [PERIOD_W-1:0] p_fix;
  logic [TIME_W-1:0]   win;
  logic [TIME_W-1:0]   exec_sh;
  logic [TIME_W:0]     win_sum;
  logic [TIME_W:0]     win_sh;
  logic [MINF_W-1:0]   mn_d;
  logic [FRAME_W-1:0]  mx_d;
  logic [HP_W-1:0]     dvd;
  logic [FRAME_W-1:0]  dvs;
  logic                div_done;
  logic [HP_W-1:0]     div_quo;
  logic [FRAME_W-1:0]  div_rem;
  logic [PROD_W-1:0]   prod_d;
  logic                out_free;
  result_t             res_d;

  // zero period behaves as period one
  assign p_fix = (task_i.period == '0) ? PERIOD_W'(1) : task_i.period;
  assign win   = (task_i.deadline >= task_i.phase) ? task_i.deadline - task_i.phase
                                                   : task_i.phase - task_i.deadline;

  // frame bounds from the fixed point maxima
  assign exec_sh = max_exec_q >> FRAC_BITS;
  assign mn_d    = (|exec_sh[TIME_W-1:MINF_W]) ? '1 : exec_sh[MINF_W-1:0];
  assign win_sum = {1'b0, max_win_q} + RND;
  assign win_sh  = win_sum >> FRAC_BITS;
  assign mx_d    = (win_sh > MX_SAT) ? MX_SAT[FRAME_W-1:0] : win_sh[FRAME_W-1:0];

  always_comb begin
    case (cmd_i.div_sel)
      DIV_GCD: begin
        dvd = gcd_a_q;
        dvs = gcd_b_q;
      end
      DIV_LCM: begin
        dvd = hyper_q;
        dvs = gcd_a_q[FRAME_W-1:0];
      end
      DIV_SEARCH: begin
        dvd = hyper_q;
        dvs = cand_q[FRAME_W-1:0];
      end
      default: begin
        dvd = hyper_q;
        dvs = cand_q[FRAME_W-1:0];
      end
    endcase
  end

  cfss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign prod_d   = PROD_W'(div_quo) * PROD_W'(period_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    res_d             = '0;
    res_d.kind        = cmd_i.emit_kind;
    res_d.last_result = cmd_i.emit_last;
    if (cmd_i.emit_kind == KIND_SUMMARY) begin
      res_d.hyperperiod = hyper_q;
      res_d.min_frame   = mn_q;
      res_d.max_frame   = mx_q;
      res_d.overflow    = ovf_q;
    end else if (cmd_i.emit_kind == KIND_FOUND) begin
      res_d.frame_size  = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyper_q     <= '0;
      ovf_q       <= 1'b0;
      first_q     <= 1'b1;
      max_exec_q  <= '0;
      max_win_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_task) begin
        if (first_q) begin
          hyper_q <= HP_W'(p_fix);
          first_q <= 1'b0;
        end
        if (task_i.exec_time > max_exec_q) max_exec_q <= task_i.exec_time;
        if (win > max_win_q) max_win_q <= win;
      end
      if (cmd_i.lcm_store) begin
        if (|prod_q[PROD_W-1:HP_W]) begin
          hyper_q <= '1;
          ovf_q   <= 1'b1;
        end else begin
          hyper_q <= prod_q[HP_W-1:0];
        end
      end
      if (cmd_i.prep) count_q <= '0;
      else if (cmd_i.take) count_q <= count_q + 1'b1;
      if (cmd_i.clear_run) begin
        hyper_q    <= '0;
        ovf_q      <= 1'b0;
        first_q    <= 1'b1;
        max_exec_q <= '0;
        max_win_q  <= '0;
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_task) begin
      period_q   <= p_fix;
      last_q     <= task_i.last_task;
      need_gcd_q <= !first_q && !ovf_q;
      gcd_a_q    <= hyper_q;
      gcd_b_q    <= FRAME_W'(p_fix);
    end
    if (cmd_i.gcd_step) begin
      gcd_a_q <= HP_W'(gcd_b_q);
      gcd_b_q <= div_rem;
    end
    if (cmd_i.lcm_mul) prod_q <= prod_d;
    if (cmd_i.prep) begin
      mn_q   <= mn_d;
      mx_q   <= mx_d;
      cand_q <= (mn_d == '0) ? CAND_W'(1) : CAND_W'(mn_d);
    end
    if (cmd_i.take) pend_q <= cand_q[FRAME_W-1:0];
    if (cmd_i.cand_inc) cand_q <= cand_q + 1'b1;
    if (cmd_i.emit) out_q <= res_d;
  end

  always_comb begin
    st_o            = '0;
    st_o.need_gcd   = need_gcd_q;
    st_o.b_zero     = (gcd_b_q == '0);
    st_o.div_done   = div_done;
    st_o.rem_zero   = (div_rem == '0);
    st_o.cand_above = cand_q > {1'b0, mx_q};
    st_o.last_task  = last_q;
    st_o.out_free   = out_free;
    st_o.count_zero = (count_q == '0);
    st_o.count_full = (count_q == CNT_W'(MAX_FOUND));
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_emit_into_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result written over an untaken transfer");

  a_saturate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lcm_store && (|prod_q[PROD_W-1:HP_W]) |=> (hyper_q == '1) && ovf_q)
    else $error("hyperperiod overflow not saturated");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_FOUND))
    else $error("found count beyond limit");

  a_take_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take |-> (count_q != CNT_W'(MAX_FOUND)))
    else $error("frame size taken with full list");

endmodule
`default_nettype wire

### sv/cfss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfss_ctrl - sequencer of the frame size search
// steps euclid, lcm update, summary and candidate walk through the datapath
// ----------------------------------------------------------------------------
module cfss_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire cfss_pkg::status_t st_i,
  output cfss_pkg::cmd_t         cmd_o,
  output logic                   ready_o
);
  import cfss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_GCD_TEST,
    S_GCD_WAIT,
    S_LCM_DIV,
    S_LCM_WAIT,
    S_LCM_STORE,
    S_CHECK_LAST,
    S_EMIT_SUM,
    S_SEARCH_TEST,
    S_SEARCH_WAIT,
    S_FOUND,
    S_CUT,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;

  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          cmd_o.load_task = 1'b1;
          ready_d         = 1'b0;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = st_i.need_gcd ? S_GCD_TEST : S_CHECK_LAST;
      end
      S_GCD_TEST: begin
        if (st_i.b_zero) begin
          state_d = S_LCM_DIV;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_GCD;
          state_d         = S_GCD_WAIT;
        end
      end
      S_GCD_WAIT: begin
        cmd_o.div_sel = DIV_GCD;
        if (st_i.div_done) begin
          cmd_o.gcd_step = 1'b1;
          state_d        = S_GCD_TEST;
        end
      end
      S_LCM_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_LCM;
        state_d         = S_LCM_WAIT;
      end
      S_LCM_WAIT: begin
        cmd_o.div_sel = DIV_LCM;
        if (st_i.div_done) begin
          cmd_o.lcm_mul = 1'b1;
          state_d       = S_LCM_STORE;
        end
      end
      S_LCM_STORE: begin
        cmd_o.lcm_store = 1'b1;
        state_d         = S_CHECK_LAST;
      end
      S_CHECK_LAST: begin
        if (st_i.last_task) begin
          cmd_o.prep = 1'b1;
          state_d    = S_EMIT_SUM;
        end else begin
          ready_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMIT_SUM: begin
        if (st_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_SUMMARY;
          state_d         = S_SEARCH_TEST;
        end
      end
      S_SEARCH_TEST: begin
        cmd_o.div_sel = DIV_SEARCH;
        if (st_i.cand_above) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_SEARCH_WAIT;
        end
      end
      S_SEARCH_WAIT: begin
        cmd_o.div_sel = DIV_SEARCH;
        if (st_i.div_done) begin
          if (st_i.rem_zero) begin
            state_d = S_FOUND;
          end else begin
            cmd_o.cand_inc = 1'b1;
            state_d        = S_SEARCH_TEST;
          end
        end
      end
      S_FOUND: begin
        // the held size goes out once a later one shows it is not last, or at finish as the last result
        if (st_i.count_zero) begin
          cmd_o.take     = 1'b1;
          cmd_o.cand_inc = 1'b1;
          state_d        = S_SEARCH_TEST;
        end else if (st_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_FOUND;
          if (st_i.count_full) begin
            state_d = S_CUT;
          end else begin
            cmd_o.take     = 1'b1;
            cmd_o.cand_inc = 1'b1;
            state_d        = S_SEARCH_TEST;
          end
        end
      end
      S_CUT: begin
        if (st_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_CUT;
          cmd_o.emit_last = 1'b1;
          cmd_o.clear_run = 1'b1;
          ready_d         = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_FINISH: begin
        if (st_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = st_i.count_zero ? KIND_NONE : KIND_FOUND;
          cmd_o.emit_last = 1'b1;
          cmd_o.clear_run = 1'b1;
          ready_d         = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        ready_d = 1'b1;
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  assign ready_o = ready_q;

  a_ready_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> state_q == S_IDLE)
    else $error("ready outside idle");

  a_wait_has_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (state_q == S_GCD_WAIT) || (state_q == S_LCM_WAIT)
                        || (state_q == S_SEARCH_WAIT))
    else $error("divider started without a wait state");

  a_load_when_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_task |-> ready_q && (state_q == S_IDLE))
    else $error("task loaded while sequencer busy");

endmodule
`default_nettype wire
